@@ rtl/mrts_pkg.sv @@
package mrts_pkg;

	// Rotating task slots, 1..SLOT_COUNT
	localparam int SLOT_COUNT = 5;
	localparam int SLOT_W     = 3;

	// Prescalers
	localparam int NUM_DIV  = 5;
	localparam int PERIOD_W = 10;
	localparam int DIV_IDX_W = 3;

	// Timers
	localparam int MAIN_W = 16;
	localparam int WORK_W = 32;

	// Configuration port
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// Stream widths
	localparam int S_DATA_W = 40;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 16;

	// Operation codes
	localparam logic [S_USER_W-1:0] OP_TICK       = 2'd0;
	localparam logic [S_USER_W-1:0] OP_START_MAIN = 2'd1;
	localparam logic [S_USER_W-1:0] OP_START_WORK = 2'd2;

	typedef logic [PERIOD_W-1:0] period_t;
	typedef period_t [NUM_DIV-1:0] period_arr_t;

	// Reset periods a..e
	localparam period_arr_t PERIOD_RESET = {
		10'd1000, 10'd500, 10'd250, 10'd100, 10'd10
	};

	// Index of the blink prescaler
	localparam int BLINK_DIV = 2;

	// Per-word control into the timers
	typedef struct packed {
		logic              tick;
		logic              suspend;
		logic              start_main;
		logic              start_work;
		logic [WORK_W-1:0] value;
	} tmr_ctl_t;

	// Busy flags after the word
	typedef struct packed {
		logic main_busy;
		logic work_busy;
	} tmr_sts_t;

	// One result word
	typedef struct packed {
		logic              work_busy;
		logic              main_busy;
		logic [SLOT_W-1:0] task_slot;
		logic              blink_level;
		logic [NUM_DIV-1:0] pulse;
	} result_t;

endpackage

@@ rtl/mrts_cfg.sv @@
module mrts_cfg import mrts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output period_arr_t       periods
);

	period_arr_t periods_q;
	logic [DIV_IDX_W-1:0] idx;
	logic wr_en;

	assign idx    = paddr[APB_AW-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// Write period registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			periods_q <= PERIOD_RESET;
		end else if (wr_en && (idx < DIV_IDX_W'(NUM_DIV))) begin
			periods_q[idx] <= pwdata[PERIOD_W-1:0];
		end
	end

	// Read back, zero beyond the register list
	always_comb begin
		prdata = '0;
		if (idx < DIV_IDX_W'(NUM_DIV))
			prdata = {{(APB_DW-PERIOD_W){1'b0}}, periods_q[idx]};
	end

	assign periods = periods_q;

endmodule

@@ rtl/mrts_presc.sv @@
module mrts_presc import mrts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    tick,
	input  period_t period,
	output logic    pulse
);

	logic [PERIOD_W-1:0] count_q;
	logic [PERIOD_W:0]   count_inc;

	// Pulse when the advanced count reaches the period
	assign count_inc = {1'b0, count_q} + (PERIOD_W+1)'(1);
	assign pulse     = tick && (count_inc >= {1'b0, period});

	// Advance, restart after a pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (tick) begin
			count_q <= pulse ? '0 : count_inc[PERIOD_W-1:0];
		end
	end

endmodule

@@ rtl/mrts_timers.sv @@
module mrts_timers import mrts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  tmr_ctl_t ctl,
	output tmr_sts_t sts
);

	logic [MAIN_W-1:0] main_rem_q, main_rem_d;
	logic [WORK_W-1:0] work_rem_q, work_rem_d;
	logic              main_run_q, main_run_d;
	logic              work_run_q, work_run_d;

	// Load on start, step on tick (main holds while suspended): stop at zero, else count down
	always_comb begin
		main_rem_d = main_rem_q;
		main_run_d = main_run_q;
		work_rem_d = work_rem_q;
		work_run_d = work_run_q;
		if (ctl.start_main) begin
			main_rem_d = ctl.value[MAIN_W-1:0];
			main_run_d = 1'b1;
		end else if (ctl.tick && !ctl.suspend && main_run_q) begin
			if (main_rem_q == '0)
				main_run_d = 1'b0;
			else
				main_rem_d = main_rem_q - MAIN_W'(1);
		end
		if (ctl.start_work) begin
			work_rem_d = ctl.value;
			work_run_d = 1'b1;
		end else if (ctl.tick && work_run_q) begin
			if (work_rem_q == '0)
				work_run_d = 1'b0;
			else
				work_rem_d = work_rem_q - WORK_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_rem_q <= '0;
			main_run_q <= 1'b0;
			work_rem_q <= '0;
			work_run_q <= 1'b0;
		end else begin
			main_rem_q <= main_rem_d;
			main_run_q <= main_run_d;
			work_rem_q <= work_rem_d;
			work_run_q <= work_run_d;
		end
	end

	assign sts.main_busy = main_run_d;
	assign sts.work_busy = work_run_d;

endmodule

@@ rtl/multi_rate_tick_scheduler.sv @@
// Channel   Dir  Width  Content
// s_axis    in   40+2   tick or timer start word
// m_axis    out  16     pulses, blink, slot, busy flags
// apb       in   32     period_a..period_e at 0x00..0x10
//
// One result word per input word; a word is taken every clock cycle while
// m_axis keeps up. The result waits in a single output register.
// s_tready stays high while that register is empty or being drained,
// so a stall on m_axis holds the input side by exactly one word.
// arst_n clears all counters, timers and the output valid; periods return
// to 10, 100, 250, 500 and 1000.
module multi_rate_tick_scheduler import mrts_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // start_value[31:0], suspend_main[32], zero pad
	input  logic [S_USER_W-1:0] s_tuser,   // op[1:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // pulse_a..pulse_e[4:0], blink_level[5],
	                                       // task_slot[8:6], main_busy[9], work_busy[10], zero pad
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready
);

	period_arr_t        periods;
	logic               accept;
	logic               tick;
	logic [NUM_DIV-1:0] pulse;
	tmr_ctl_t           tmr_ctl;
	tmr_sts_t           tmr_sts;
	logic [SLOT_W-1:0]  slot_q, slot_d;
	logic [SLOT_W:0]    slot_inc;
	logic               blink_q, blink_d;
	result_t            res_q;
	logic               m_tvalid_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign tick     = accept && (s_tuser == OP_TICK);

	mrts_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.periods (periods)
	);

	// One prescaler per divided rate
	for (genvar i = 0; i < NUM_DIV; i++) begin : g_presc
		mrts_presc u_presc (
			.clk    (clk),
			.arst_n (arst_n),
			.tick   (tick),
			.period (periods[i]),
			.pulse  (pulse[i])
		);
	end

	// Decode the word into timer control
	assign tmr_ctl.tick       = tick;
	assign tmr_ctl.suspend    = s_tdata[WORK_W];
	assign tmr_ctl.start_main = accept && (s_tuser == OP_START_MAIN);
	assign tmr_ctl.start_work = accept && (s_tuser == OP_START_WORK);
	assign tmr_ctl.value      = s_tdata[WORK_W-1:0];

	mrts_timers u_timers (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tmr_ctl),
		.sts    (tmr_sts)
	);

	// Rotate the slot on tick; toggle blink on a tick with a blink prescaler pulse
	assign slot_inc = {1'b0, slot_q} + (SLOT_W+1)'(1);
	always_comb begin
		slot_d  = slot_q;
		blink_d = blink_q;
		if (tick) begin
			if (slot_inc >= (SLOT_W+1)'(SLOT_COUNT + 1))
				slot_d = SLOT_W'(1);
			else
				slot_d = slot_inc[SLOT_W-1:0];
			blink_d = blink_q ^ pulse[BLINK_DIV];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			blink_q <= 1'b0;
		end else begin
			slot_q  <= slot_d;
			blink_q <= blink_d;
		end
	end

	// Output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.pulse       <= pulse;
			res_q.blink_level <= blink_d;
			res_q.task_slot   <= slot_d;
			res_q.main_busy   <= tmr_sts.main_busy;
			res_q.work_busy   <= tmr_sts.work_busy;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_DATA_W-$bits(result_t))'(0), res_q};

endmodule

@@ bench/tb_multi_rate_tick_scheduler.sv @@
module tb_multi_rate_tick_scheduler;
	import mrts_pkg::*;

	// Op code with no function in the block
	localparam logic [S_USER_W-1:0] OP_UNUSED = 2'd3;

	// Register indexes of the period registers
	localparam int REG_PERIOD_A = 0;
	localparam int REG_PERIOD_B = 1;
	localparam int REG_PERIOD_C = 2;
	localparam int REG_PERIOD_D = 3;
	localparam int REG_PERIOD_E = 4;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;   // start_value[31:0], suspend_main[32], zero pad
	logic [S_USER_W-1:0] s_tuser = '0;   // op[1:0]
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;        // pulse_a..pulse_e[4:0], blink_level[5],
	                                     // task_slot[8:6], main_busy[9], work_busy[10], zero pad
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	// Scheduler state as the bench predicts it
	logic [PERIOD_W-1:0] sched_period [NUM_DIV];
	logic [PERIOD_W-1:0] sched_count [NUM_DIV];
	logic                sched_blink;
	logic [SLOT_W-1:0]   sched_slot;
	logic [MAIN_W-1:0]   main_left;
	logic                main_on;
	logic [WORK_W-1:0]   work_left;
	logic                work_on;

	result_t pending_results [$];
	int      mismatch_count = 0;
	int      tx_idle_pct = 0;
	int      rx_stall_pct = 0;
	string   pulse_field [NUM_DIV] = '{"pulse_a", "pulse_b", "pulse_c", "pulse_d", "pulse_e"};

	multi_rate_tick_scheduler u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Advance the predicted state by one word and return the result it causes
	function automatic result_t advance_scheduler(input logic [S_USER_W-1:0] op,
			input logic [WORK_W-1:0] value, input logic suspend);
		result_t           r;
		logic [PERIOD_W:0] next_count;
		logic [SLOT_W:0]   next_slot;
		r = '0;
		case (op)
			OP_TICK: begin
				if (!suspend && main_on) begin
					if (main_left == '0)
						main_on = 1'b0;
					else
						main_left = main_left - 1'b1;
				end
				next_slot = sched_slot + 1'b1;
				if (next_slot >= SLOT_COUNT + 1)
					next_slot = (SLOT_W+1)'(1);
				sched_slot = next_slot[SLOT_W-1:0];
				for (int i = 0; i < NUM_DIV; i++) begin
					next_count = {1'b0, sched_count[i]} + 1'b1;
					if (next_count >= sched_period[i]) begin
						next_count = '0;
						r.pulse[i] = 1'b1;
					end
					sched_count[i] = next_count[PERIOD_W-1:0];
				end
				if (r.pulse[BLINK_DIV])
					sched_blink = ~sched_blink;
				if (work_on) begin
					if (work_left == '0)
						work_on = 1'b0;
					else
						work_left = work_left - 1'b1;
				end
			end
			OP_START_MAIN: begin
				main_left = value[MAIN_W-1:0];
				main_on = 1'b1;
			end
			OP_START_WORK: begin
				work_left = value;
				work_on = 1'b1;
			end
			default: ;
		endcase
		r.blink_level = sched_blink;
		r.task_slot = sched_slot;
		r.main_busy = main_on;
		r.work_busy = work_on;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] expv,
			input logic [31:0] gotv);
		if (mismatch_count < 50)
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, expv, gotv);
		mismatch_count++;
	endtask

	// Result side: stall at random, compare each word with the oldest prediction
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	always @(posedge clk) begin : result_check
		result_t want;
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[$bits(result_t)-1:0]);
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result word", '0, 32'(m_tdata));
			end else begin
				want = pending_results.pop_front();
				for (int i = 0; i < NUM_DIV; i++)
					if (got.pulse[i] !== want.pulse[i])
						report_mismatch(pulse_field[i], 32'(want.pulse[i]),
							32'(got.pulse[i]));
				if (got.blink_level !== want.blink_level)
					report_mismatch("blink_level", 32'(want.blink_level),
						32'(got.blink_level));
				if (got.task_slot !== want.task_slot)
					report_mismatch("task_slot", 32'(want.task_slot), 32'(got.task_slot));
				if (got.main_busy !== want.main_busy)
					report_mismatch("main_busy", 32'(want.main_busy), 32'(got.main_busy));
				if (got.work_busy !== want.work_busy)
					report_mismatch("work_busy", 32'(want.work_busy), 32'(got.work_busy));
				if (m_tdata[M_DATA_W-1:$bits(result_t)] !== '0)
					report_mismatch("m_tdata pad", '0, 32'(m_tdata));
			end
		end
	end

	// Send one word, with a random gap first; valid stays high for a following word
	task automatic send_word(input logic [S_USER_W-1:0] op, input logic [WORK_W-1:0] value,
			input logic suspend);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_DATA_W-WORK_W-1){1'b0}}, suspend, value};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(advance_scheduler(op, value, suspend));
	endtask

	task automatic send_random_words(input int count);
		logic [S_USER_W-1:0] op;
		logic [WORK_W-1:0]   value;
		logic                suspend;
		int                  pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 72)
				op = OP_TICK;
			else if (pick < 82)
				op = OP_START_MAIN;
			else if (pick < 94)
				op = OP_START_WORK;
			else
				op = OP_UNUSED;
			// Mostly short counts so the timers run out, some full-width values
			case ($urandom_range(3))
				0: value = $urandom_range(12);
				1: value = {16'($urandom()), 16'($urandom_range(30))};
				2: value = $urandom();
				default: value = $urandom_range(60);
			endcase
			suspend = ($urandom_range(99) < 25);
			send_word(op, value, suspend);
		end
	endtask

	// Hold input until every predicted word has come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write one period register, then read it back
	task automatic write_period(input int idx, input logic [PERIOD_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(4 * idx);
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sched_period[idx] = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DW'(value))
			report_mismatch("period readback", APB_DW'(value), prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_all_periods(input logic [PERIOD_W-1:0] pa, input logic [PERIOD_W-1:0] pb,
			input logic [PERIOD_W-1:0] pc, input logic [PERIOD_W-1:0] pd,
			input logic [PERIOD_W-1:0] pe);
		wait_idle();
		write_period(REG_PERIOD_A, pa);
		write_period(REG_PERIOD_B, pb);
		write_period(REG_PERIOD_C, pc);
		write_period(REG_PERIOD_D, pd);
		write_period(REG_PERIOD_E, pe);
		@(posedge clk);
	endtask

	task automatic set_idle(input int tx, input int rx);
		tx_idle_pct = tx;
		rx_stall_pct = rx;
	endtask

	// Timer corner cases, unused op, field extremes, slot wrap, first fast pulse
	task automatic test_directed();
		send_word(OP_UNUSED, 32'hFFFF_FFFF, 1'b1);
		send_word(OP_TICK, 32'h0, 1'b1);
		// start with zero count: busy until the first unsuspended tick steps it
		send_word(OP_START_MAIN, 32'hFFFF_0000, 1'b1);
		send_word(OP_TICK, 32'hFFFF_FFFF, 1'b1);
		send_word(OP_TICK, 32'h0, 1'b0);
		send_word(OP_START_WORK, 32'h0, 1'b0);
		send_word(OP_TICK, 32'h0, 1'b0);
		send_word(OP_START_WORK, 32'hFFFF_FFFF, 1'b0);
		send_word(OP_START_MAIN, 32'h0000_FFFF, 1'b0);
		send_word(OP_START_MAIN, 32'hABCD_0002, 1'b0);
		repeat (3) send_word(OP_TICK, 32'h5555_AAAA, 1'b0);
		send_word(OP_START_WORK, 32'h3, 1'b1);
		for (int n = 0; n < 8; n++)
			send_word(OP_TICK, 32'hAAAA_5555, n[0]);
	endtask

	task automatic test_default_rates();
		send_random_words(300);
	endtask

	task automatic test_shortest_periods();
		write_all_periods(10'd1, 10'd2, 10'd3, 10'd4, 10'd5);
		send_random_words(150);
	endtask

	// Longest periods, with one full drain in the middle
	task automatic test_longest_periods();
		write_all_periods(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
		send_random_words(75);
		wait_idle();
		send_random_words(75);
	endtask

	// Drop periods below the running counts: next tick pulses and restarts
	task automatic test_lowered_periods();
		write_all_periods(10'd2, 10'd9, 10'd25, 10'd40, 10'd50);
		send_random_words(100);
	endtask

	// Zero period pulses on every tick
	task automatic test_zero_periods();
		write_all_periods(10'd0, 10'd1, 10'd0, 10'd2, 10'd1023);
		send_random_words(80);
	endtask

	task automatic test_random_periods();
		for (int round = 0; round < 3; round++) begin
			write_all_periods(PERIOD_W'($urandom_range(40, 1)),
				PERIOD_W'($urandom_range(40, 1)), PERIOD_W'($urandom_range(40, 1)),
				PERIOD_W'($urandom_range(40, 1)), PERIOD_W'($urandom_range(40, 1)));
			send_random_words(80);
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_DIV; i++) begin
			sched_period[i] = PERIOD_RESET[i];
			sched_count[i] = '0;
		end
		sched_blink = 1'b0;
		sched_slot = '0;
		main_left = '0;
		main_on = 1'b0;
		work_left = '0;
		work_on = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idle(11, 71);
		test_directed();
		test_default_rates();
		test_shortest_periods();
		set_idle(71, 11);
		test_longest_periods();
		test_lowered_periods();
		test_zero_periods();
		set_idle(0, 0);
		test_random_periods();

		// Drain, then allow the output register to settle
		s_tvalid <= 1'b0;
		for (int n = 0; n < 5000 && pending_results.size() != 0; n++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("words never returned", pending_results.size(), '0);

		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
